/* sv/bbf_pkg.sv */
// ============================================================================
// bbf_pkg
// Shared types and constants for the bounded byte FIFO.
// ============================================================================
package bbf_pkg;

  localparam int CNT_W   = 11;   // counts, capacity, pop request
  localparam int OFF_W   = 10;   // peek offset
  localparam int BYTE_W  = 8;
  localparam int TOT_W   = 64;
  localparam int OP_W    = 3;

  localparam logic [CNT_W-1:0] CAP_RESET = 11'd1024;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH    = 3'd0,
    OP_POP     = 3'd1,
    OP_CLOSE   = 3'd2,
    OP_SET_ERR = 3'd3,
    OP_PEEK    = 3'd4
  } op_t;

  // One result, minus the byte that comes from the store.
  typedef struct packed {
    logic              accepted;
    logic              peek_hit;   // read_byte comes from the store
    logic [CNT_W-1:0]  removed;
    logic [CNT_W-1:0]  buffered;
    logic [CNT_W-1:0]  room_left;
    logic [TOT_W-1:0]  total_pushed;
    logic [TOT_W-1:0]  total_popped;
    logic              closed;
    logic              error;
    logic              finished;
  } res_t;

endpackage

/* sv/bbf_ram.sv */
// ============================================================================
// bbf_ram
// Byte store: one write port, one read port, registered read data.
// ============================================================================
module bbf_ram #(
  parameter int DEPTH = 1024
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [bbf_pkg::BYTE_W-1:0] wdata,
  input  logic                       re,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [bbf_pkg::BYTE_W-1:0] rdata
);

  logic [bbf_pkg::BYTE_W-1:0] mem [DEPTH];
  logic [bbf_pkg::BYTE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read holds its data while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* sv/bbf_core.sv */
// ============================================================================
// bbf_core
// FIFO state, capacity register and per-operation next-state/result logic.
// ============================================================================
module bbf_core #(
  parameter int DEPTH = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [bbf_pkg::CNT_W-1:0]   cfg_wdata,
  input  logic                        take,
  input  logic [bbf_pkg::OP_W-1:0]    opcode,
  input  logic [bbf_pkg::BYTE_W-1:0]  data_byte,
  input  logic [bbf_pkg::CNT_W-1:0]   pop_count,
  input  logic [bbf_pkg::OFF_W-1:0]   peek_offset,
  output logic                        mem_we,
  output logic [$clog2(DEPTH)-1:0]    mem_waddr,
  output logic [bbf_pkg::BYTE_W-1:0]  mem_wdata,
  output logic                        mem_re,
  output logic [$clog2(DEPTH)-1:0]    mem_raddr,
  output bbf_pkg::res_t               res
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int SUM_W = ((IDX_W > bbf_pkg::CNT_W) ? IDX_W : bbf_pkg::CNT_W) + 1;
  localparam logic [16:0]      DEPTH_L = 17'(DEPTH);
  localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(DEPTH);

  logic [bbf_pkg::CNT_W-1:0]  cap_r;
  logic [IDX_W-1:0]           head_r,   head_nxt;
  logic [bbf_pkg::CNT_W-1:0]  fill_r,   fill_nxt;
  logic [bbf_pkg::TOT_W-1:0]  pushed_r, pushed_nxt;
  logic [bbf_pkg::TOT_W-1:0]  popped_r, popped_nxt;
  logic                       closed_r, closed_nxt;
  logic                       error_r,  error_nxt;

  logic [bbf_pkg::CNT_W-1:0]  lim;
  logic [bbf_pkg::CNT_W-1:0]  pop_n;
  logic [bbf_pkg::CNT_W-1:0]  off_sel;
  logic [SUM_W-1:0]           sum_raw;
  logic [SUM_W-1:0]           sum_wrap;
  logic [IDX_W-1:0]           slot;
  logic [bbf_pkg::CNT_W-1:0]  peek_off_x;
  bbf_pkg::op_t               op;

  assign op         = bbf_pkg::op_t'(opcode);
  assign peek_off_x = bbf_pkg::CNT_W'(peek_offset);
  assign lim   = ({6'd0, cap_r} > DEPTH_L) ? bbf_pkg::CNT_W'(DEPTH) : cap_r;
  assign pop_n = (pop_count < fill_r) ? pop_count : fill_r;

  // one shared ring-index adder; every offset used is at most DEPTH
  always_comb begin
    case (op)
      bbf_pkg::OP_PUSH: off_sel = fill_r;
      bbf_pkg::OP_POP:  off_sel = pop_n;
      default:          off_sel = peek_off_x;
    endcase
  end

  assign sum_raw  = SUM_W'(head_r) + SUM_W'(off_sel);
  assign sum_wrap = (sum_raw >= DEPTH_S) ? (sum_raw - DEPTH_S) : sum_raw;
  assign slot     = sum_wrap[IDX_W-1:0];

  always_comb begin
    head_nxt   = head_r;
    fill_nxt   = fill_r;
    pushed_nxt = pushed_r;
    popped_nxt = popped_r;
    closed_nxt = closed_r;
    error_nxt  = error_r;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    res.accepted = 1'b0;
    res.peek_hit = 1'b0;
    res.removed  = '0;
    case (op)
      bbf_pkg::OP_PUSH: begin
        if (fill_r < lim) begin
          mem_we       = take;
          fill_nxt     = fill_r + 1'b1;
          pushed_nxt   = pushed_r + 1'b1;
          res.accepted = 1'b1;
        end
      end
      bbf_pkg::OP_POP: begin
        head_nxt    = slot;
        fill_nxt    = fill_r - pop_n;
        popped_nxt  = popped_r + bbf_pkg::TOT_W'(pop_n);
        res.removed = pop_n;
      end
      bbf_pkg::OP_CLOSE:   closed_nxt = 1'b1;
      bbf_pkg::OP_SET_ERR: error_nxt  = 1'b1;
      bbf_pkg::OP_PEEK: begin
        if (peek_off_x < fill_r) begin
          mem_re       = take;
          res.accepted = 1'b1;
          res.peek_hit = 1'b1;
        end
      end
      default: ;
    endcase
    res.buffered     = fill_nxt;
    res.room_left    = (lim > fill_nxt) ? (lim - fill_nxt) : '0;
    res.total_pushed = pushed_nxt;
    res.total_popped = popped_nxt;
    res.closed       = closed_nxt;
    res.error        = error_nxt;
    res.finished     = closed_nxt && (fill_nxt == '0);
  end

  assign mem_waddr = slot;
  assign mem_wdata = data_byte;
  assign mem_raddr = slot;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r    <= bbf_pkg::CAP_RESET;
      head_r   <= '0;
      fill_r   <= '0;
      pushed_r <= '0;
      popped_r <= '0;
      closed_r <= 1'b0;
      error_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (take) begin
        head_r   <= head_nxt;
        fill_r   <= fill_nxt;
        pushed_r <= pushed_nxt;
        popped_r <= popped_nxt;
        closed_r <= closed_nxt;
        error_r  <= error_nxt;
      end
    end
  end

endmodule

/* sv/bounded_byte_fifo.sv */
// ============================================================================
// bounded_byte_fifo
// Byte FIFO with a programmable fill limit; one result per operation.
// ============================================================================
//
//   channel   ports                          transfer when
//   -------   ----------------------------   -------------------------
//   input     in_valid/in_ready + fields     in_valid && in_ready
//   result    out_valid/out_ready + fields   out_valid && out_ready
//   config    cfg_we, cfg_wdata (capacity)   cfg_we high at clock edge
//
// One operation per clock while in_ready is high. An operation updates the
// FIFO state on the edge it transfers in; its result enters the output register
// on that same edge, with the peek byte taken from the store's registered read port.
// in_ready drops only while the output register holds an untaken result.
// Reset (rst_n low, synchronous) empties the FIFO, clears totals and flags,
// and sets capacity to 1024; store contents are not cleared.
// ============================================================================
module bounded_byte_fifo #(
  parameter int DEPTH = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // capacity register
  input  logic                        cfg_we,
  input  logic [bbf_pkg::CNT_W-1:0]   cfg_wdata,
  // operation in
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [bbf_pkg::OP_W-1:0]    in_opcode,
  input  logic [bbf_pkg::BYTE_W-1:0]  in_data_byte,
  input  logic [bbf_pkg::CNT_W-1:0]   in_pop_count,
  input  logic [bbf_pkg::OFF_W-1:0]   in_peek_offset,
  // result out
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_accepted,
  output logic [bbf_pkg::BYTE_W-1:0]  out_read_byte,
  output logic [bbf_pkg::CNT_W-1:0]   out_removed,
  output logic [bbf_pkg::CNT_W-1:0]   out_buffered,
  output logic [bbf_pkg::CNT_W-1:0]   out_room_left,
  output logic [bbf_pkg::TOT_W-1:0]   out_total_pushed,
  output logic [bbf_pkg::TOT_W-1:0]   out_total_popped,
  output logic                        out_closed_flag,
  output logic                        out_error_flag,
  output logic                        out_finished_flag
);

  localparam int IDX_W = $clog2(DEPTH);

  logic                       take;
  logic                       out_valid_r, out_valid_nxt;
  bbf_pkg::res_t              res_nxt;
  bbf_pkg::res_t              res_r;

  logic                       mem_we;
  logic [IDX_W-1:0]           mem_waddr;
  logic [bbf_pkg::BYTE_W-1:0] mem_wdata;
  logic                       mem_re;
  logic [IDX_W-1:0]           mem_raddr;
  logic [bbf_pkg::BYTE_W-1:0] mem_rdata;

  // single output register: refills in the same cycle it is drained
  assign in_ready = !out_valid_r || out_ready;
  assign take     = in_valid && in_ready;

  bbf_core #(
    .DEPTH (DEPTH)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .take        (take),
    .opcode      (in_opcode),
    .data_byte   (in_data_byte),
    .pop_count   (in_pop_count),
    .peek_offset (in_peek_offset),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_re      (mem_re),
    .mem_raddr   (mem_raddr),
    .res         (res_nxt)
  );

  // read data only changes on a peek transfer, so it holds through stalls
  bbf_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_accepted      = res_r.accepted;
  assign out_read_byte     = res_r.peek_hit ? mem_rdata : '0;
  assign out_removed       = res_r.removed;
  assign out_buffered      = res_r.buffered;
  assign out_room_left     = res_r.room_left;
  assign out_total_pushed  = res_r.total_pushed;
  assign out_total_popped  = res_r.total_popped;
  assign out_closed_flag   = res_r.closed;
  assign out_error_flag    = res_r.error;
  assign out_finished_flag = res_r.finished;

endmodule

/* tb/bounded_byte_fifo_checker.sv */
// ----------------------------------------------------------------------------
// bounded_byte_fifo_checker
// Watches the operation, result and capacity ports of the byte FIFO, keeps
// its own copy of the queue state and compares each result transfer, field
// by field, against the oldest predicted result.
// ----------------------------------------------------------------------------
module bounded_byte_fifo_checker #(
  parameter int DEPTH = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [bbf_pkg::CNT_W-1:0]   cfg_wdata,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [bbf_pkg::OP_W-1:0]    in_opcode,
  input  logic [bbf_pkg::BYTE_W-1:0]  in_data_byte,
  input  logic [bbf_pkg::CNT_W-1:0]   in_pop_count,
  input  logic [bbf_pkg::OFF_W-1:0]   in_peek_offset,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic                        out_accepted,
  input  logic [bbf_pkg::BYTE_W-1:0]  out_read_byte,
  input  logic [bbf_pkg::CNT_W-1:0]   out_removed,
  input  logic [bbf_pkg::CNT_W-1:0]   out_buffered,
  input  logic [bbf_pkg::CNT_W-1:0]   out_room_left,
  input  logic [bbf_pkg::TOT_W-1:0]   out_total_pushed,
  input  logic [bbf_pkg::TOT_W-1:0]   out_total_popped,
  input  logic                        out_closed_flag,
  input  logic                        out_error_flag,
  input  logic                        out_finished_flag,
  output int unsigned                 mismatches,
  output int unsigned                 outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDX_W = $clog2(DEPTH);

  typedef struct packed {
    logic                       accepted;
    logic [bbf_pkg::BYTE_W-1:0] read_byte;
    logic [bbf_pkg::CNT_W-1:0]  removed;
    logic [bbf_pkg::CNT_W-1:0]  buffered;
    logic [bbf_pkg::CNT_W-1:0]  room_left;
    logic [bbf_pkg::TOT_W-1:0]  total_pushed;
    logic [bbf_pkg::TOT_W-1:0]  total_popped;
    logic                       closed;
    logic                       error;
    logic                       finished;
  } fifo_result_t;

  // mirrored queue state
  logic [bbf_pkg::BYTE_W-1:0] byte_mem [DEPTH];
  logic [IDX_W-1:0]           head;
  logic [bbf_pkg::CNT_W-1:0]  fill;
  logic [bbf_pkg::TOT_W-1:0]  pushed_sum;
  logic [bbf_pkg::TOT_W-1:0]  popped_sum;
  logic                       closed_seen;
  logic                       error_seen;
  logic [bbf_pkg::CNT_W-1:0]  cap_reg;

  fifo_result_t awaited_results [$];
  int unsigned  fault_tally  = 0;
  int unsigned  waiting_now  = 0;

  assign mismatches  = fault_tally;
  assign outstanding = waiting_now;

  function automatic int unsigned slot_of(input logic [bbf_pkg::CNT_W-1:0] off);
    return (int'(head) + int'(off)) % DEPTH;
  endfunction

  task automatic apply_fifo_op(input logic [bbf_pkg::OP_W-1:0] opcode,
                               input logic [bbf_pkg::BYTE_W-1:0] data,
                               input logic [bbf_pkg::CNT_W-1:0] want,
                               input logic [bbf_pkg::OFF_W-1:0] offset,
                               output fifo_result_t res);
    logic [bbf_pkg::CNT_W-1:0] lim;
    logic [bbf_pkg::CNT_W-1:0] take;
    res = '0;
    lim = (cap_reg > bbf_pkg::CNT_W'(DEPTH)) ? bbf_pkg::CNT_W'(DEPTH) : cap_reg;
    case (opcode)
      bbf_pkg::OP_PUSH: begin
        if (fill < lim) begin
          byte_mem[slot_of(fill)] = data;
          fill         = fill + 1'b1;
          pushed_sum   = pushed_sum + 1'b1;
          res.accepted = 1'b1;
        end
      end
      bbf_pkg::OP_POP: begin
        take        = (want < fill) ? want : fill;
        head        = IDX_W'(slot_of(take));
        fill        = fill - take;
        popped_sum  = popped_sum + bbf_pkg::TOT_W'(take);
        res.removed = take;
      end
      bbf_pkg::OP_CLOSE: begin
        closed_seen = 1'b1;
      end
      bbf_pkg::OP_SET_ERR: begin
        error_seen = 1'b1;
      end
      bbf_pkg::OP_PEEK: begin
        if (bbf_pkg::CNT_W'(offset) < fill) begin
          res.read_byte = byte_mem[slot_of(bbf_pkg::CNT_W'(offset))];
          res.accepted  = 1'b1;
        end
      end
      default: begin
      end
    endcase
    res.buffered     = fill;
    res.room_left    = (lim > fill) ? lim - fill : '0;
    res.total_pushed = pushed_sum;
    res.total_popped = popped_sum;
    res.closed       = closed_seen;
    res.error        = error_seen;
    res.finished     = closed_seen && (fill == '0);
  endtask

  task automatic check_field(input string label, input logic [bbf_pkg::TOT_W-1:0] want_v,
                             input logic [bbf_pkg::TOT_W-1:0] got_v);
    if (got_v !== want_v) begin
      fault_tally++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, label, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    fifo_result_t predicted;
    fifo_result_t oldest;
    if (!rst_n) begin
      head        = '0;
      fill        = '0;
      pushed_sum  = '0;
      popped_sum  = '0;
      closed_seen = 1'b0;
      error_seen  = 1'b0;
      cap_reg     = bbf_pkg::CAP_RESET;
      awaited_results.delete();
    end else begin
      if (cfg_we) cap_reg = cfg_wdata;
      if (in_valid && in_ready) begin
        apply_fifo_op(in_opcode, in_data_byte, in_pop_count, in_peek_offset, predicted);
        awaited_results.push_back(predicted);
      end
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          fault_tally++;
          $display("%0t: unexpected result, expected none actual buffered=%0d",
                   $time, out_buffered);
        end else begin
          oldest = awaited_results.pop_front();
          check_field("accepted", bbf_pkg::TOT_W'(oldest.accepted),
                      bbf_pkg::TOT_W'(out_accepted));
          check_field("read_byte", bbf_pkg::TOT_W'(oldest.read_byte),
                      bbf_pkg::TOT_W'(out_read_byte));
          check_field("removed", bbf_pkg::TOT_W'(oldest.removed),
                      bbf_pkg::TOT_W'(out_removed));
          check_field("buffered", bbf_pkg::TOT_W'(oldest.buffered),
                      bbf_pkg::TOT_W'(out_buffered));
          check_field("room_left", bbf_pkg::TOT_W'(oldest.room_left),
                      bbf_pkg::TOT_W'(out_room_left));
          check_field("total_pushed", oldest.total_pushed, out_total_pushed);
          check_field("total_popped", oldest.total_popped, out_total_popped);
          check_field("closed_flag", bbf_pkg::TOT_W'(oldest.closed),
                      bbf_pkg::TOT_W'(out_closed_flag));
          check_field("error_flag", bbf_pkg::TOT_W'(oldest.error),
                      bbf_pkg::TOT_W'(out_error_flag));
          check_field("finished_flag", bbf_pkg::TOT_W'(oldest.finished),
                      bbf_pkg::TOT_W'(out_finished_flag));
        end
      end
    end
    waiting_now <= awaited_results.size();
  end

endmodule

/* tb/bounded_byte_fifo_tb.sv */
// ----------------------------------------------------------------------------
// bounded_byte_fifo_tb
// Stimulus for the byte FIFO: a directed opening on empty, full and
// over-limit queues, then phases of random operations under a range of
// capacity settings. Sender bursts and receiver stalls are randomized; the
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module bounded_byte_fifo_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          FIFO_DEPTH   = 1024;
  localparam int          RESET_CYCLES = 8;
  localparam int          DRAIN_CYCLES = 20;
  localparam int          LONG_HOLD    = 90;
  localparam int          N_PHASES     = 10;
  localparam int unsigned CNT_MAX      = (1 << bbf_pkg::CNT_W) - 1;
  localparam int unsigned OFF_MAX      = (1 << bbf_pkg::OFF_W) - 1;

  // opcodes the block treats as no operation
  localparam logic [bbf_pkg::OP_W-1:0] OP_NOP_FIRST = 3'd5;
  localparam logic [bbf_pkg::OP_W-1:0] OP_NOP_LAST  = 3'd7;

  logic                        clk            = 1'b0;
  logic                        rst_n          = 1'b0;
  logic                        cfg_we         = 1'b0;
  logic [bbf_pkg::CNT_W-1:0]   cfg_wdata      = '0;
  logic                        in_valid       = 1'b0;
  logic                        in_ready;
  logic [bbf_pkg::OP_W-1:0]    in_opcode      = '0;
  logic [bbf_pkg::BYTE_W-1:0]  in_data_byte   = '0;
  logic [bbf_pkg::CNT_W-1:0]   in_pop_count   = '0;
  logic [bbf_pkg::OFF_W-1:0]   in_peek_offset = '0;
  logic                        out_valid;
  logic                        out_ready      = 1'b0;
  logic                        out_accepted;
  logic [bbf_pkg::BYTE_W-1:0]  out_read_byte;
  logic [bbf_pkg::CNT_W-1:0]   out_removed;
  logic [bbf_pkg::CNT_W-1:0]   out_buffered;
  logic [bbf_pkg::CNT_W-1:0]   out_room_left;
  logic [bbf_pkg::TOT_W-1:0]   out_total_pushed;
  logic [bbf_pkg::TOT_W-1:0]   out_total_popped;
  logic                        out_closed_flag;
  logic                        out_error_flag;
  logic                        out_finished_flag;

  int unsigned mismatches;
  int unsigned outstanding;

  // sender bookkeeping, shared with the receiver's hold trigger
  int unsigned sent_count = 0;
  int unsigned burst_left = 5;
  logic        offering   = 1'b0;

  // random phases: capacity, number of operations, share of pushes in percent.
  // Small capacities keep the queue near full so drops are common; the large
  // ones let the ring pointer travel around the store. A small capacity right
  // after a large one lands below the fill level.
  int unsigned phase_cap  [N_PHASES] = '{16, 1, 2047, 5, 0, 37, 1024, 3, 200, 8};
  int unsigned phase_len  [N_PHASES] = '{150, 60, 250, 100, 30, 150, 300, 80, 100, 80};
  int unsigned phase_push [N_PHASES] = '{60, 55, 85, 50, 40, 60, 85, 50, 65, 45};

  always #6 clk = ~clk;

  bounded_byte_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_data_byte      (in_data_byte),
    .in_pop_count      (in_pop_count),
    .in_peek_offset    (in_peek_offset),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_accepted      (out_accepted),
    .out_read_byte     (out_read_byte),
    .out_removed       (out_removed),
    .out_buffered      (out_buffered),
    .out_room_left     (out_room_left),
    .out_total_pushed  (out_total_pushed),
    .out_total_popped  (out_total_popped),
    .out_closed_flag   (out_closed_flag),
    .out_error_flag    (out_error_flag),
    .out_finished_flag (out_finished_flag)
  );

  bounded_byte_fifo_checker #(
    .DEPTH (FIFO_DEPTH)
  ) checker_i (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_data_byte      (in_data_byte),
    .in_pop_count      (in_pop_count),
    .in_peek_offset    (in_peek_offset),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_accepted      (out_accepted),
    .out_read_byte     (out_read_byte),
    .out_removed       (out_removed),
    .out_buffered      (out_buffered),
    .out_room_left     (out_room_left),
    .out_total_pushed  (out_total_pushed),
    .out_total_popped  (out_total_popped),
    .out_closed_flag   (out_closed_flag),
    .out_error_flag    (out_error_flag),
    .out_finished_flag (out_finished_flag),
    .mismatches        (mismatches),
    .outstanding       (outstanding)
  );

  // Offer one operation and hold it until the transfer. Called right after a
  // rising edge, so every drive below lands as an edge-aligned update. When
  // the burst runs out, valid drops and the sender sits out a random gap;
  // otherwise valid stays high and the next call just swaps the payload.
  task automatic send_op(input logic [bbf_pkg::OP_W-1:0] op,
                         input logic [bbf_pkg::BYTE_W-1:0] data,
                         input logic [bbf_pkg::CNT_W-1:0] cnt,
                         input logic [bbf_pkg::OFF_W-1:0] off);
    in_opcode      <= op;
    in_data_byte   <= data;
    in_pop_count   <= cnt;
    in_peek_offset <= off;
    in_valid       <= 1'b1;
    offering        = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      offering  = 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk);
      // now and then a long burst, so some stretches run with no sender gaps
      burst_left = ($urandom_range(4) == 0) ? $urandom_range(60, 25) : $urandom_range(12, 1);
    end
  endtask

  // Drop valid if a burst was cut short by the end of a phase.
  task automatic sender_idle();
    if (offering) begin
      in_valid <= 1'b0;
      offering  = 1'b0;
    end
  endtask

  // Capacity changes only while the block is idle: let the outstanding count
  // catch up with the last transfer, then wait until every result is taken.
  task automatic set_capacity(input logic [bbf_pkg::CNT_W-1:0] value);
    sender_idle();
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // One random operation. Counts and offsets mostly stay near the fill level
  // so pops and peeks hit real data; the rest reach across the whole field,
  // including pop requests above the store size. All fields carry noise
  // whatever the opcode.
  task automatic send_random_op(input int unsigned push_pct, input int unsigned span);
    int unsigned                pick;
    logic [bbf_pkg::OP_W-1:0]   op;
    logic [bbf_pkg::CNT_W-1:0]  cnt;
    logic [bbf_pkg::OFF_W-1:0]  off;
    if ($urandom_range(99) < push_pct) begin
      op = bbf_pkg::OP_PUSH;
    end else begin
      pick = $urandom_range(99);
      if (pick < 45) op = bbf_pkg::OP_POP;
      else if (pick < 80) op = bbf_pkg::OP_PEEK;
      else if (pick < 86) op = bbf_pkg::OP_CLOSE;
      else if (pick < 92) op = bbf_pkg::OP_SET_ERR;
      else op = bbf_pkg::OP_W'($urandom_range(OP_NOP_LAST, OP_NOP_FIRST));
    end
    pick = $urandom_range(9);
    if (pick < 6) cnt = bbf_pkg::CNT_W'($urandom_range(4));
    else if (pick < 8) cnt = bbf_pkg::CNT_W'($urandom_range(span));
    else cnt = bbf_pkg::CNT_W'($urandom_range(CNT_MAX, FIFO_DEPTH));
    if ($urandom_range(3) == 0) off = bbf_pkg::OFF_W'($urandom_range(OFF_MAX));
    else off = bbf_pkg::OFF_W'($urandom_range(span));
    send_op(op, bbf_pkg::BYTE_W'($urandom_range(255)), cnt, off);
  endtask

  // Receiver: segments of steady ready, coin-flip ready, sparse ready and
  // short stalls. Twice, once enough operations have gone in, it holds off
  // for a long stretch so the output register stays full and the input
  // channel backs up while the sender keeps offering.
  initial begin : receiver
    int unsigned mode;
    int unsigned seg_len;
    int unsigned holds_done;
    holds_done = 0;
    forever begin
      if (holds_done < 2 && sent_count >= ((holds_done == 0) ? 300 : 900)) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        holds_done++;
      end else begin
        mode    = $urandom_range(3);
        seg_len = (mode == 3) ? $urandom_range(6, 1) : $urandom_range(40, 4);
        repeat (seg_len) begin
          case (mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(1));
            2:       out_ready <= ($urandom_range(3) == 0);
            default: out_ready <= 1'b0;
          endcase
          @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned span;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // -- directed: reset capacity, empty queue
    send_op(bbf_pkg::OP_POP, 8'h00, 11'd0, 10'd0);      // pop nothing from empty
    send_op(bbf_pkg::OP_PEEK, 8'h00, 11'd0, 10'd0);     // peek into empty queue
    send_op(bbf_pkg::OP_PUSH, 8'h00, 11'd0, 10'd0);
    send_op(bbf_pkg::OP_PUSH, 8'hFF, 11'd0, 10'd0);
    send_op(bbf_pkg::OP_PUSH, 8'h5A, 11'd0, 10'd0);
    send_op(bbf_pkg::OP_PEEK, 8'h00, 11'd0, 10'd0);     // front
    send_op(bbf_pkg::OP_PEEK, 8'h00, 11'd0, 10'd2);     // last held byte
    send_op(bbf_pkg::OP_PEEK, 8'h00, 11'd0, 10'd3);     // offset equal to fill: miss
    send_op(bbf_pkg::OP_PEEK, 8'hFF, 11'd0, 10'h3FF);   // widest offset: miss
    send_op(OP_NOP_FIRST, 8'hC3, 11'd5, 10'd1);         // unused opcodes change nothing
    send_op(OP_NOP_LAST, 8'h3C, 11'h7FF, 10'h3FF);
    send_op(bbf_pkg::OP_POP, 8'h00, 11'd1, 10'd0);
    send_op(bbf_pkg::OP_POP, 8'h00, 11'h7FF, 10'd0);    // request above fill: clamped

    // -- directed: tiny capacity, push into a full queue
    set_capacity(11'd2);
    send_op(bbf_pkg::OP_PUSH, 8'hA5, 11'd0, 10'd0);
    send_op(bbf_pkg::OP_PUSH, 8'h3C, 11'd0, 10'd0);
    send_op(bbf_pkg::OP_PUSH, 8'hFF, 11'd0, 10'd0);     // dropped

    // -- directed: capacity lowered below fill, nothing discarded
    set_capacity(11'd0);
    send_op(bbf_pkg::OP_PUSH, 8'h11, 11'd0, 10'd0);     // dropped, room stays 0
    send_op(bbf_pkg::OP_PEEK, 8'h00, 11'd0, 10'd1);
    send_op(bbf_pkg::OP_POP, 8'h00, 11'd1024, 10'd0);

    // -- directed: capacity above store size, close and error flags
    set_capacity(11'h7FF);
    send_op(bbf_pkg::OP_PUSH, 8'h81, 11'd0, 10'd0);
    send_op(bbf_pkg::OP_CLOSE, 8'h00, 11'd0, 10'd0);
    send_op(bbf_pkg::OP_SET_ERR, 8'h00, 11'd0, 10'd0);
    send_op(bbf_pkg::OP_PUSH, 8'h7E, 11'd0, 10'd0);     // push after close still lands
    send_op(bbf_pkg::OP_POP, 8'h00, 11'd2, 10'd0);      // empties a closed stream
    send_op(bbf_pkg::OP_PEEK, 8'h00, 11'd0, 10'd0);

    // -- random phases
    for (int p = 0; p < N_PHASES; p++) begin
      set_capacity(bbf_pkg::CNT_W'(phase_cap[p]));
      span = (phase_cap[p] > 400) ? 400 : phase_cap[p] + 2;
      repeat (phase_len[p]) send_random_op(phase_push[p], span);
    end

    // -- drain and verdict
    sender_idle();
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog, several times the slowest expected run.
  initial begin : watchdog
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule
